// ===== design/mpfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mpfb_pkg
// Shared constants, codes and control structs for the page-organized
// monochrome frame store pixel engine.
// ----------------------------------------------------------------------------
package mpfb_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 64;
  localparam int PAGE_ROWS   = 8;
  localparam int PAGES       = (MAX_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES = MAX_WIDTH * PAGES;
  localparam int ADDR_BITS   = $clog2(STORE_BYTES);
  localparam int DIM_BITS    = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                               $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  localparam int SUM_BITS    = 2 * DIM_BITS + 1;

  // request kinds
  localparam logic [1:0] KIND_DRAW  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // pixel colors
  localparam logic [1:0] COLOR_BLACK   = 2'd0;
  localparam logic [1:0] COLOR_WHITE   = 2'd1;
  localparam logic [1:0] COLOR_INVERSE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_ROTATION = 2'd2;

  typedef struct packed {
    logic load_item;
    logic calc;
    logic mem_read;
    logic mem_write;
    logic clear_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       clear_last;
    logic       out_free;
  } status_t;

endpackage

// ===== design/mpfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpfb_ctrl
// Sequencer for the pixel engine: reset wipe, request decode, memory
// read-modify-write steps, clear sweep and result hand-off.
// ----------------------------------------------------------------------------
module mpfb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mpfb_pkg::status_t status,
  output mpfb_pkg::cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_WIPE  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_CALC  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_CLEAR = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_WIPE: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        case (status.kind) inside
          mpfb_pkg::KIND_DRAW,
          mpfb_pkg::KIND_READ:  state_next = S_READ;
          mpfb_pkg::KIND_CLEAR: state_next = S_CLEAR;
          default:              state_next = S_DONE;
        endcase
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = (status.kind == mpfb_pkg::KIND_DRAW) ? S_WRITE : S_DONE;
      end
      S_WRITE: begin
        cmd.mem_write = 1'b1;
        state_next    = S_DONE;
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_WIPE;
      end
    endcase
  end

endmodule

// ===== design/mpfb_dp.sv =====
// ----------------------------------------------------------------------------
// mpfb_dp
// Datapath for the pixel engine: configuration registers, request
// registers, rotation and address arithmetic, frame memory, clear counter
// and result register.
// ----------------------------------------------------------------------------
module mpfb_dp (
  input  logic                clk,
  input  logic                rst,
  input  mpfb_pkg::cmd_t      cmd,
  output mpfb_pkg::status_t   status,
  input  logic [1:0]          kind,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  input  logic [1:0]          color,
  input  logic [9:0]          byte_index,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          read_data,
  output logic                pixel_hit
);

  localparam int DB = mpfb_pkg::DIM_BITS;
  localparam int SB = mpfb_pkg::SUM_BITS;
  localparam int AB = mpfb_pkg::ADDR_BITS;

  logic [7:0] panel_width;
  logic [6:0] panel_height;
  logic [1:0] rotation;

  logic [1:0]         item_kind;
  logic signed [15:0] item_x;
  logic signed [15:0] item_y;
  logic [1:0]         item_color;
  logic [9:0]         item_index;

  logic [AB-1:0] addr;
  logic          hit;
  logic [7:0]    mask;
  logic [AB-1:0] clear_pointer;
  logic [7:0]    mem [mpfb_pkg::STORE_BYTES];
  logic [7:0]    rdata;

  logic [DB-1:0] w_eff, h_eff, lw, lh, xs, ys, col, row, page;
  logic          x_ok, y_ok, color_ok, lin_ok, index_ok;
  logic [SB-1:0] lin;
  logic [7:0]    wdata, modified;
  logic [AB-1:0] mem_addr;
  logic          mem_we;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= 8'd128;
      panel_height <= 7'd64;
      rotation     <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpfb_pkg::REG_WIDTH:    panel_width  <= cfg_data;
        mpfb_pkg::REG_HEIGHT:   panel_height <= cfg_data[6:0];
        mpfb_pkg::REG_ROTATION: rotation     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_kind  <= kind;
      item_x     <= pos_x;
      item_y     <= pos_y;
      item_color <= color;
      item_index <= byte_index;
    end
  end

  // bounds and rotation
  always_comb begin
    w_eff = ({1'b0, panel_width} > 9'(mpfb_pkg::MAX_WIDTH)) ?
            DB'(mpfb_pkg::MAX_WIDTH) : DB'(panel_width);
    h_eff = ({1'b0, panel_height} > 8'(mpfb_pkg::MAX_HEIGHT)) ?
            DB'(mpfb_pkg::MAX_HEIGHT) : DB'(panel_height);
    lw    = rotation[0] ? h_eff : w_eff;
    lh    = rotation[0] ? w_eff : h_eff;
    x_ok  = !item_x[15] && (item_x[14:0] < 15'(lw));
    y_ok  = !item_y[15] && (item_y[14:0] < 15'(lh));
    color_ok = (item_color == mpfb_pkg::COLOR_BLACK) ||
               (item_color == mpfb_pkg::COLOR_WHITE) ||
               (item_color == mpfb_pkg::COLOR_INVERSE);
    xs = item_x[DB-1:0];
    ys = item_y[DB-1:0];
    case (rotation)
      2'd1: begin
        col = w_eff - DB'(1) - ys;
        row = xs;
      end
      2'd2: begin
        col = w_eff - DB'(1) - xs;
        row = h_eff - DB'(1) - ys;
      end
      2'd3: begin
        col = ys;
        row = h_eff - DB'(1) - xs;
      end
      default: begin
        col = xs;
        row = ys;
      end
    endcase
    page     = row >> 3;
    lin      = SB'(col) + SB'(page) * SB'(w_eff);
    lin_ok   = lin < SB'(mpfb_pkg::STORE_BYTES);
    index_ok = {1'b0, item_index} < 11'(mpfb_pkg::STORE_BYTES);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      if (item_kind == mpfb_pkg::KIND_DRAW) begin
        addr <= AB'(lin);
        hit  <= x_ok && y_ok && color_ok && lin_ok;
      end else begin
        addr <= AB'(item_index);
        hit  <= index_ok;
      end
      mask <= 8'b1 << row[2:0];
    end
  end

  // read-modify-write of one byte
  always_comb begin
    case (item_color)
      mpfb_pkg::COLOR_BLACK: modified = rdata & ~mask;
      mpfb_pkg::COLOR_WHITE: modified = rdata | mask;
      default:               modified = rdata ^ mask;
    endcase
    mem_addr = cmd.clear_step ? clear_pointer : addr;
    mem_we   = cmd.clear_step || (cmd.mem_write && hit);
    wdata    = cmd.clear_step ? 8'd0 : modified;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wdata;
    end
    if (cmd.mem_read) begin
      rdata <= mem[mem_addr];
    end
  end

  // clear sweep counter, back to zero after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_pointer <= '0;
    end else if (cmd.clear_step) begin
      if (status.clear_last) begin
        clear_pointer <= '0;
      end else begin
        clear_pointer <= clear_pointer + AB'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_data <= (item_kind == mpfb_pkg::KIND_READ && hit) ? rdata : 8'd0;
      pixel_hit <= (item_kind == mpfb_pkg::KIND_DRAW) && hit;
    end
  end

  always_comb begin
    status.kind       = item_kind;
    status.clear_last = (clear_pointer == AB'(mpfb_pkg::STORE_BYTES - 1));
    status.out_free   = !out_valid || !out_stall;
  end

endmodule

// ===== design/mono_page_framebuffer_pixel_engine.sv =====
// ----------------------------------------------------------------------------
// mono_page_framebuffer_pixel_engine
// Monochrome page-organized frame store with pixel draw, clear and read.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one request: kind, pos_x,
// pos_y, color, byte_index. Output channel (out_valid / out_stall) returns
// one result per request: read_data and pixel_hit.
// The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data)
// writes panel_width (0), panel_height (1) and rotation (2); write it only
// while no request is in flight. cfg_ready is always high.
// One request is in work at a time through a single-port frame memory:
//   draw: decode, address, read, write, result; read: decode,
//         address, read, result; kind 3: decode, address, result;
//   clear: decode, address, one memory byte written per cycle, result.
// The result sits in an output register; a new request is accepted while
// it waits, and a later result holds in the sequencer until the register
// frees. After reset the block sweeps the 1024-byte store to zero, with
// in_stall high throughout the sweep; configuration resets to 128 x 64,
// rotation 0.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_pixel_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [1:0]         color,
  input  logic [9:0]         byte_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         read_data,
  output logic               pixel_hit,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  mpfb_pkg::cmd_t    cmd;
  mpfb_pkg::status_t status;

  assign cfg_ready = 1'b1;

  mpfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mpfb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .kind       (kind),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .color      (color),
    .byte_index (byte_index),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .pixel_hit  (pixel_hit)
  );

endmodule

// ===== tb/sv/mpfb_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mpfb_result_checker
// Watches the request, result and configuration channels of the pixel
// engine. Keeps a shadow frame store and panel setup, predicts each result
// in order, and compares every returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module mpfb_result_checker
  import mpfb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [1:0]         color,
  input  logic [9:0]         byte_index,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         read_data,
  input  logic               pixel_hit,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output int                 mismatches,
  output int                 outstanding
);

  localparam logic [1:0] ROT_NONE    = 2'd0;
  localparam logic [1:0] ROT_QUARTER = 2'd1;
  localparam logic [1:0] ROT_HALF    = 2'd2;
  localparam logic [1:0] ROT_THREE_Q = 2'd3;

  typedef struct packed {
    logic [7:0] read_data;
    logic       pixel_hit;
  } pixel_result_t;

  logic [7:0]    shadow_store [STORE_BYTES];
  logic [7:0]    shadow_width;
  logic [6:0]    shadow_height;
  logic [1:0]    shadow_rot;
  pixel_result_t awaited_results [$];

  // Apply one request to the shadow store and return the result it yields.
  function automatic pixel_result_t engine_outcome(input logic [1:0] k,
                                                   input logic signed [15:0] px,
                                                   input logic signed [15:0] py,
                                                   input logic [1:0] c,
                                                   input logic [9:0] bi);
    pixel_result_t        res;
    int                   w, h, lw, lh, x, y, col, row, addr;
    logic [7:0]           mask;
    logic [ADDR_BITS-1:0] aidx;
    res = '0;
    case (k)
      KIND_DRAW: begin
        w  = (shadow_width > MAX_WIDTH) ? MAX_WIDTH : int'(shadow_width);
        h  = (shadow_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(shadow_height);
        // quarter turns swap the logical bounds
        lw = shadow_rot[0] ? h : w;
        lh = shadow_rot[0] ? w : h;
        x  = px;
        y  = py;
        if (x >= 0 && x < lw && y >= 0 && y < lh && c <= COLOR_INVERSE) begin
          case (shadow_rot)
            ROT_QUARTER: begin col = w - 1 - y; row = x;         end
            ROT_HALF:    begin col = w - 1 - x; row = h - 1 - y; end
            ROT_THREE_Q: begin col = y;         row = h - 1 - x; end
            default:     begin col = x;         row = y;         end
          endcase
          addr = col + (row / PAGE_ROWS) * w;
          if (addr < STORE_BYTES) begin
            aidx = ADDR_BITS'(addr);
            mask = 8'(1 << (row % PAGE_ROWS));
            case (c)
              COLOR_WHITE: shadow_store[aidx] = shadow_store[aidx] | mask;
              COLOR_BLACK: shadow_store[aidx] = shadow_store[aidx] & ~mask;
              default:     shadow_store[aidx] = shadow_store[aidx] ^ mask;
            endcase
            res.pixel_hit = 1'b1;
          end
        end
      end
      KIND_CLEAR: begin
        foreach (shadow_store[i]) shadow_store[i] = '0;
      end
      KIND_READ: begin
        if (bi < STORE_BYTES) res.read_data = shadow_store[bi];
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    if (rst) begin
      foreach (shadow_store[i]) shadow_store[i] = '0;
      shadow_width  = 8'(MAX_WIDTH);
      shadow_height = 7'(MAX_HEIGHT);
      shadow_rot    = ROT_NONE;
      awaited_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH:    shadow_width  = cfg_data;
          REG_HEIGHT:   shadow_height = cfg_data[6:0];
          REG_ROTATION: shadow_rot    = cfg_data[1:0];
          default: ;
        endcase
      end
      // results leaving now belong to requests accepted earlier: pop first
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got read_data=%02h pixel_hit=%b",
                   $time, read_data, pixel_hit);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (read_data !== want.read_data) begin
            $display("%0t: read_data mismatch, expected %02h, got %02h",
                     $time, want.read_data, read_data);
            mismatches++;
          end
          if (pixel_hit !== want.pixel_hit) begin
            $display("%0t: pixel_hit mismatch, expected %b, got %b",
                     $time, want.pixel_hit, pixel_hit);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(engine_outcome(kind, pos_x, pos_y, color, byte_index));
    end
    outstanding = awaited_results.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the monochrome page frame store pixel engine.
// Directed draws, reads and clears at the edges of the panel, then phases of
// random requests under changing panel size, rotation and channel pressure.
// ----------------------------------------------------------------------------
module tb;
  import mpfb_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] COLOR_KEEP  = 2'd3;
  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam int         PHASES      = 10;
  localparam int         PHASE_ITEMS = 100;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic [1:0]         kind       = '0;
  logic signed [15:0] pos_x      = '0;
  logic signed [15:0] pos_y      = '0;
  logic [1:0]         color      = '0;
  logic [9:0]         byte_index = '0;
  logic               out_stall  = 1'b0;
  logic               cfg_valid  = 1'b0;
  logic [1:0]         cfg_index  = '0;
  logic [7:0]         cfg_data   = '0;
  logic               in_stall;
  logic               out_valid;
  logic [7:0]         read_data;
  logic               pixel_hit;
  logic               cfg_ready;

  int         mismatches;
  int         outstanding;
  int         gap_pct   = 0;
  int         stall_pct = 0;
  int         panel_w   = MAX_WIDTH;
  int         panel_h   = MAX_HEIGHT;
  logic [1:0] panel_rot = '0;

  // panel setup per phase; -1 picks a random legal value
  int phase_w [PHASES] = '{128, 255, 1, 0, 64, 8, 100, 128, -1, 33};
  int phase_h [PHASES] = '{64, 127, 64, 64, 0, 8, 1, 64, -1, 24};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  mono_page_framebuffer_pixel_engine u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .color      (color),
    .byte_index (byte_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .pixel_hit  (pixel_hit),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mpfb_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .color       (color),
    .byte_index  (byte_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .pixel_hit   (pixel_hit),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(negedge clk) out_stall = ($urandom_range(0, 99) < stall_pct);

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Present one request and hold it until the engine takes it.
  task automatic send_request(input logic [1:0] k, input logic [15:0] x,
                              input logic [15:0] y, input logic [1:0] c,
                              input logic [9:0] bi);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    kind       = k;
    pos_x      = x;
    pos_y      = y;
    color      = c;
    byte_index = bi;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold off new requests until every predicted result has come back.
  task automatic wait_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_panel(input int w, input int h, input logic [1:0] r);
    write_reg(REG_WIDTH, 8'(w));
    write_reg(REG_HEIGHT, 8'(h));
    write_reg(REG_ROTATION, {6'(0), r});
    panel_w   = w;
    panel_h   = h;
    panel_rot = r;
  endtask

  function automatic logic [1:0] pick_color();
    int c;
    c = $urandom_range(0, 9);
    if (c < 4) return COLOR_WHITE;
    if (c < 6) return COLOR_BLACK;
    if (c < 9) return COLOR_INVERSE;
    return COLOR_KEEP;
  endfunction

  task automatic random_request();
    int sel, w, h, lw, lh, span;
    sel  = $urandom_range(0, 99);
    w    = (panel_w > MAX_WIDTH) ? MAX_WIDTH : panel_w;
    h    = (panel_h > MAX_HEIGHT) ? MAX_HEIGHT : panel_h;
    lw   = panel_rot[0] ? h : w;
    lh   = panel_rot[0] ? w : h;
    span = w * ((h + PAGE_ROWS - 1) / PAGE_ROWS);
    if (sel < 60) begin
      // mostly in bounds, one step past the far edge now and then
      send_request(KIND_DRAW, 16'($urandom_range(0, lw)), 16'($urandom_range(0, lh)),
                   pick_color(), 10'($urandom));
    end else if (sel < 85) begin
      if (span == 0 || $urandom_range(0, 4) == 0)
        send_request(KIND_READ, 16'($urandom), 16'($urandom), 2'($urandom),
                     10'($urandom));
      else
        send_request(KIND_READ, 16'($urandom), 16'($urandom), 2'($urandom),
                     10'($urandom_range(0, span - 1)));
    end else if (sel < 88) begin
      send_request(KIND_CLEAR, 16'($urandom), 16'($urandom), 2'($urandom), 10'($urandom));
    end else if (sel < 91) begin
      send_request(KIND_UNUSED, 16'($urandom), 16'($urandom), 2'($urandom),
                   10'($urandom));
    end else begin
      send_request(KIND_DRAW, 16'($urandom), 16'($urandom), 2'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    int w, h;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset panel: corners, edges, colors, unused kind, clear
    send_request(KIND_DRAW, 16'd0, 16'd0, COLOR_WHITE, 10'd0);
    send_request(KIND_DRAW, 16'd127, 16'd63, COLOR_WHITE, 10'd1023);
    send_request(KIND_READ, 16'd0, 16'd0, COLOR_BLACK, 10'd0);
    send_request(KIND_READ, 16'hFFFF, 16'hFFFF, COLOR_KEEP, 10'd1023);
    send_request(KIND_DRAW, 16'd128, 16'd0, COLOR_WHITE, 10'd0);
    send_request(KIND_DRAW, 16'd0, 16'd64, COLOR_WHITE, 10'd0);
    send_request(KIND_DRAW, 16'hFFFF, 16'd5, COLOR_WHITE, 10'd0);
    send_request(KIND_DRAW, 16'h8000, 16'h7FFF, COLOR_WHITE, 10'd0);
    send_request(KIND_DRAW, 16'h7FFF, 16'h8000, COLOR_INVERSE, 10'd0);
    send_request(KIND_DRAW, 16'd5, 16'd5, COLOR_KEEP, 10'd0);
    send_request(KIND_DRAW, 16'd0, 16'd0, COLOR_INVERSE, 10'd0);
    send_request(KIND_DRAW, 16'd3, 16'd9, COLOR_INVERSE, 10'd0);
    send_request(KIND_DRAW, 16'd127, 16'd63, COLOR_BLACK, 10'd0);
    send_request(KIND_READ, 16'd0, 16'd0, COLOR_BLACK, 10'd0);
    send_request(KIND_READ, 16'd0, 16'd0, COLOR_BLACK, 10'd1023);
    send_request(KIND_READ, 16'd0, 16'd0, COLOR_BLACK, 10'd131);
    send_request(KIND_UNUSED, 16'hFFFF, 16'hFFFF, COLOR_KEEP, 10'h3FF);
    send_request(KIND_DRAW, 16'd64, 16'd32, COLOR_WHITE, 10'd0);
    send_request(KIND_CLEAR, 16'd0, 16'd0, COLOR_BLACK, 10'd0);
    send_request(KIND_READ, 16'd0, 16'd0, COLOR_BLACK, 10'd131);
    send_request(KIND_READ, 16'd0, 16'd0, COLOR_BLACK, 10'd576);
    wait_results();

    // quarter turn on a narrow panel: bounds swap
    set_panel(16, 8, 2'd1);
    write_reg(REG_UNUSED, 8'($urandom));
    send_request(KIND_DRAW, 16'd7, 16'd15, COLOR_WHITE, 10'd0);
    send_request(KIND_DRAW, 16'd8, 16'd0, COLOR_WHITE, 10'd0);
    send_request(KIND_READ, 16'd0, 16'd0, COLOR_BLACK, 10'd0);
    wait_results();

    for (int p = 0; p < PHASES; p++) begin
      w = (phase_w[p] < 0) ? $urandom_range(1, 255) : phase_w[p];
      h = (phase_h[p] < 0) ? $urandom_range(1, 127) : phase_h[p];
      set_panel(w, h, 2'(p));
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 65; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 65; end
        default: begin gap_pct = 8; stall_pct = 8; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_request();
        if ($urandom_range(0, 199) == 0) wait_results();
      end
      wait_results();
    end

    gap_pct   = 0;
    stall_pct = 0;
    wait_results();
    repeat (16) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
